>>> src/rrt_pkg.sv
// Shared types, widths and codes for the tree extension block.
package rrt_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int COORD_W = 32;
  localparam int DIFF_W = 33;
  localparam int SQ_W = 66;
  localparam int ROOT_W = 33;
  localparam int REM_W = 36;
  localparam int STEP_W = 24;
  localparam int NUM_W = 57;
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd5;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAME = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] d);
    mag33 = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

>>> src/rrt_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item and hands on.
module rrt_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  rrt_pkg::sqrt_t din,
  output rrt_pkg::sqrt_t dout
);
  import rrt_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {din.rem[REM_W-3:0], din.rad[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, din.root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rad <= {din.rad[SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      dout.rem <= rem_sh - trial;
      dout.root <= {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      dout.rem <= rem_sh;
      dout.root <= {din.root[ROOT_W-2:0], 1'b0};
    end
  end
endmodule

>>> src/rrt_divider.sv
// Two-lane restoring divider that produces one quotient bit per lane each cycle while busy.
module rrt_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rrt_pkg::NUM_W-1:0]  num_a,
  input  logic [rrt_pkg::NUM_W-1:0]  num_b,
  input  logic [rrt_pkg::ROOT_W-1:0] den,
  output logic                       done,
  output logic [rrt_pkg::NUM_W-1:0]  quo_a,
  output logic [rrt_pkg::NUM_W-1:0]  quo_b
);
  import rrt_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [ROOT_W:0]  rem_a, rem_b;
  logic [ROOT_W:0]  sh_a, sh_b;

  assign sh_a = {rem_a[ROOT_W-1:0], quo_a[NUM_W-1]};
  assign sh_b = {rem_b[ROOT_W-1:0], quo_b[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      quo_a <= num_a;
      quo_b <= num_b;
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      if (sh_a >= {1'b0, den}) begin
        rem_a <= sh_a - {1'b0, den};
        quo_a <= {quo_a[NUM_W-2:0], 1'b1};
      end else begin
        rem_a <= sh_a;
        quo_a <= {quo_a[NUM_W-2:0], 1'b0};
      end
      if (sh_b >= {1'b0, den}) begin
        rem_b <= sh_b - {1'b0, den};
        quo_b <= {quo_b[NUM_W-2:0], 1'b1};
      end else begin
        rem_b <= sh_b;
        quo_b <= {quo_b[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

>>> src/rrt_tree_extend_step.sv
// Top level of the tree extension block: node scan, step, append and result.
// For a tree of N nodes an item passes in order through the pipelined scan of the N nodes, the
// square root cell chain, the divide set-up, the divider, and the steps that saturate, test the
// goal and register the result. One item is in flight at a time; a full tree answers without a
// scan, a sample on its nearest node after the scan with no step taken. Synchronous reset leaves
// only the root, set to zero; the node memory is not cleared.
module rrt_tree_extend_step #(
  parameter int MAX_NODES = rrt_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,  // sample_x, sample_y
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [87:0]                    m_tdata,  // new_x, new_y, new_index, parent_index,
                                                   // goal_reached, zero fill
  output logic [1:0]                     m_tuser,  // status
  input  logic                           cfg_we,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import rrt_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    IDLE, SCAN, ROOT, NUMER, DIVIDE, SAT, GOAL_SQ, GOAL_CMP, DONE
  } state_t;

  state_t state;

  logic signed [31:0] start_x, start_y, goal_x, goal_y;
  logic [STEP_W-1:0]  step_length, goal_tolerance;

  logic signed [31:0] mem_x [MAX_NODES];
  logic signed [31:0] mem_y [MAX_NODES];
  logic signed [31:0] rd_x, rd_y;
  logic               mem_we;

  logic [CW-1:0] count, ra;
  logic signed [31:0] sx, sy;

  logic               p1_v, p2_v, p3_v;
  logic [CW-1:0]      p1_i, p2_i, p3_i;
  logic signed [DIFF_W-1:0] p2_dx, p2_dy, p3_dx, p3_dy;
  logic signed [31:0] p2_x, p2_y, p3_x, p3_y;
  logic [SQ_W-2:0]    p3_sqx, p3_sqy;
  logic [SQ_W-1:0]    p4_sum;

  logic [SQ_W-1:0]    best_s;
  logic [CW-1:0]      best_i;
  logic signed [31:0] best_x, best_y;
  logic signed [DIFF_W-1:0] best_dx, best_dy;

  sqrt_t chain [ROOT_W+1];
  logic  sq_start;
  logic [ROOT_W-1:0] len;

  logic [NUM_W-1:0]  numx, numy, qx, qy;
  logic              div_start, div_done;

  logic signed [58:0] tx, ty;
  logic signed [31:0] nx, ny, nx_next, ny_next;
  logic [SQ_W-2:0]    gsx, gsy;
  logic [2*STEP_W-1:0] tol2;
  logic signed [DIFF_W-1:0] gdx, gdy;

  logic [31:0]      r_x, r_y;
  logic [IDX_W-1:0] r_idx, r_par;
  logic             r_goal;
  logic [1:0]       r_status;

  assign s_tready = (state == IDLE);
  assign mem_we = (state == GOAL_CMP);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[count[AW-1:0]] <= nx;
      mem_y[count[AW-1:0]] <= ny;
    end
    rd_x <= mem_x[ra[AW-1:0]];
    rd_y <= mem_y[ra[AW-1:0]];
  end

  assign chain[0].valid = sq_start;
  assign chain[0].rad = best_s;
  assign chain[0].rem = '0;
  assign chain[0].root = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    rrt_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  rrt_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (numx),
    .num_b (numy),
    .den   (len),
    .done  (div_done),
    .quo_a (qx),
    .quo_b (qy)
  );

  assign p4_sum = {1'b0, p3_sqx} + {1'b0, p3_sqy};

  always_comb begin
    tx = 59'(best_x) + (best_dx[DIFF_W-1] ? -$signed({2'b00, qx}) : $signed({2'b00, qx}));
    ty = 59'(best_y) + (best_dy[DIFF_W-1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy}));
    if (tx > 59'sd2147483647) begin
      nx_next = 32'sh7fffffff;
    end else if (tx < -59'sd2147483648) begin
      nx_next = 32'sh80000000;
    end else begin
      nx_next = tx[31:0];
    end
    if (ty > 59'sd2147483647) begin
      ny_next = 32'sh7fffffff;
    end else if (ty < -59'sd2147483648) begin
      ny_next = 32'sh80000000;
    end else begin
      ny_next = ty[31:0];
    end
    gdx = {nx[31], nx} - {goal_x[31], goal_x};
    gdy = {ny[31], ny} - {goal_y[31], goal_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      start_x <= '0;
      start_y <= '0;
      goal_x <= '0;
      goal_y <= '0;
      step_length <= STEP_W'(32768);
      goal_tolerance <= STEP_W'(66);
      count <= CW'(1);
      ra <= '0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      sq_start <= 1'b0;
      div_start <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: begin
            start_x <= cfg_data;
            count <= CW'(1);
          end
          REG_START_Y: begin
            start_y <= cfg_data;
            count <= CW'(1);
          end
          REG_GOAL_X: goal_x <= cfg_data;
          REG_GOAL_Y: goal_y <= cfg_data;
          REG_STEP: step_length <= cfg_data[STEP_W-1:0];
          REG_TOL: goal_tolerance <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      sq_start <= 1'b0;
      div_start <= 1'b0;

      p1_v <= (state == SCAN) && (ra < count);
      p2_v <= p1_v;
      p3_v <= p2_v;
      if (state == SCAN && ra < count) begin
        ra <= ra + 1'b1;
      end
      p1_i <= ra;
      p2_i <= p1_i;
      p2_x <= (p1_i == '0) ? start_x : rd_x;
      p2_y <= (p1_i == '0) ? start_y : rd_y;
      p2_dx <= {sx[31], sx} - ((p1_i == '0) ? {start_x[31], start_x} : {rd_x[31], rd_x});
      p2_dy <= {sy[31], sy} - ((p1_i == '0) ? {start_y[31], start_y} : {rd_y[31], rd_y});
      p3_i <= p2_i;
      p3_x <= p2_x;
      p3_y <= p2_y;
      p3_dx <= p2_dx;
      p3_dy <= p2_dy;
      p3_sqx <= (SQ_W-1)'(mag33(p2_dx) * mag33(p2_dx));
      p3_sqy <= (SQ_W-1)'(mag33(p2_dy) * mag33(p2_dy));
      if (p3_v && (p3_i == '0 || p4_sum < best_s)) begin
        best_s <= p4_sum;
        best_i <= p3_i;
        best_x <= p3_x;
        best_y <= p3_y;
        best_dx <= p3_dx;
        best_dy <= p3_dy;
      end

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            sx <= s_tdata[31:0];
            sy <= s_tdata[63:32];
            ra <= '0;
            if (count >= CW'(MAX_NODES)) begin
              r_x <= '0;
              r_y <= '0;
              r_idx <= '0;
              r_par <= '0;
              r_goal <= 1'b0;
              r_status <= ST_FULL;
              state <= DONE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (ra == count && !p1_v && !p2_v && !p3_v) begin
            if (best_s == '0) begin
              r_x <= '0;
              r_y <= '0;
              r_idx <= '0;
              r_par <= IDX_W'(best_i);
              r_goal <= 1'b0;
              r_status <= ST_SAME;
              state <= DONE;
            end else begin
              sq_start <= 1'b1;
              state <= ROOT;
            end
          end
        end
        ROOT: begin
          if (chain[ROOT_W].valid) begin
            len <= chain[ROOT_W].root;
            state <= NUMER;
          end
        end
        NUMER: begin
          numx <= NUM_W'(step_length * mag33(best_dx)) + NUM_W'(len >> 1);
          numy <= NUM_W'(step_length * mag33(best_dy)) + NUM_W'(len >> 1);
          div_start <= 1'b1;
          state <= DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            state <= SAT;
          end
        end
        SAT: begin
          nx <= nx_next;
          ny <= ny_next;
          state <= GOAL_SQ;
        end
        GOAL_SQ: begin
          gsx <= (SQ_W-1)'(mag33(gdx) * mag33(gdx));
          gsy <= (SQ_W-1)'(mag33(gdy) * mag33(gdy));
          tol2 <= goal_tolerance * goal_tolerance;
          state <= GOAL_CMP;
        end
        GOAL_CMP: begin
          r_x <= nx;
          r_y <= ny;
          r_idx <= IDX_W'(count);
          r_par <= IDX_W'(best_i);
          r_goal <= ({1'b0, gsx} + {1'b0, gsy}) < SQ_W'(tol2);
          r_status <= ST_ADDED;
          count <= count + 1'b1;
          state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {3'b000, r_goal, r_par, r_idx, r_y, r_x};
            m_tuser <= r_status;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_NODES))
    else $error("node count passed the table size");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == DIVIDE)
    else $error("divider finished outside the divide step");
  assert property (@(posedge clk) disable iff (rst) p1_v |-> $past(state) == SCAN)
    else $error("node read issued outside the scan");
  assert property (@(posedge clk) disable iff (rst)
    (state == DONE && (!m_tvalid || m_tready)) |=> m_tvalid && state == IDLE)
    else $error("finished result did not reach the output register");

endmodule

>>> tb/sv/rrt_checker.sv
// Checker for the tree extension block: tracks the tree, predicts each result and compares.
module rrt_checker
  import rrt_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [63:0]          s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [87:0]          m_tdata,
  input  logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [9:0]  new_index;
    logic [9:0]  parent_index;
    logic        goal_reached;
    logic [1:0]  status;
  } extend_res_t;

  extend_res_t extend_q[$];
  int err_cnt = 0;

  logic signed [31:0] node_x [MAX_NODES];
  logic signed [31:0] node_y [MAX_NODES];
  int unsigned node_cnt;
  logic signed [31:0] root_x, root_y, goal_x, goal_y;
  logic [23:0] step_len, goal_tol;

  function automatic logic signed [33:0] diff34(logic signed [31:0] a, logic signed [31:0] b);
    return 34'(a) - 34'(b);
  endfunction

  function automatic logic [65:0] mag66(logic signed [33:0] d);
    logic [33:0] m;
    m = d[33] ? 34'(-d) : 34'(d);
    return 66'(m);
  endfunction

  function automatic logic [65:0] dist_sq(logic signed [33:0] dx, logic signed [33:0] dy);
    logic [65:0] mx, my;
    mx = mag66(dx);
    my = mag66(dy);
    return mx * mx + my * my;
  endfunction

  function automatic logic [33:0] floor_sqrt(logic [65:0] s);
    logic [33:0] r, c;
    logic [67:0] cc;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      cc = 68'(c) * 68'(c);
      if (cc <= 68'(s)) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] step_off(logic signed [33:0] d, logic [33:0] len);
    logic [63:0] q;
    q = (64'(step_len) * 64'(mag66(d)) + 64'(len >> 1)) / 64'(len);
    return d[33] ? -34'(q) : 34'(q);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7FFFFFFF;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void clear_tree();
    node_x[0] = root_x;
    node_y[0] = root_y;
    node_cnt = 1;
  endfunction

  function automatic extend_res_t extend(logic signed [31:0] sx, logic signed [31:0] sy);
    extend_res_t r;
    logic [65:0] best_d, d;
    int unsigned best;
    logic [33:0] len;
    logic signed [33:0] dx, dy;
    logic signed [31:0] nx, ny;
    logic [47:0] tol_sq;
    r = '0;
    if (node_cnt >= MAX_NODES) begin
      r.status = ST_FULL;
      return r;
    end
    best = 0;
    best_d = dist_sq(diff34(sx, node_x[0]), diff34(sy, node_y[0]));
    for (int unsigned i = 1; i < node_cnt; i++) begin
      d = dist_sq(diff34(sx, node_x[i]), diff34(sy, node_y[i]));
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    r.parent_index = best[9:0];
    if (best_d == 0) begin
      r.status = ST_SAME;
      return r;
    end
    dx = diff34(sx, node_x[best]);
    dy = diff34(sy, node_y[best]);
    len = floor_sqrt(best_d);
    nx = sat32(34'(node_x[best]) + step_off(dx, len));
    ny = sat32(34'(node_y[best]) + step_off(dy, len));
    node_x[node_cnt] = nx;
    node_y[node_cnt] = ny;
    tol_sq = 48'(goal_tol) * 48'(goal_tol);
    r.new_x = nx;
    r.new_y = ny;
    r.new_index = node_cnt[9:0];
    r.goal_reached = dist_sq(diff34(nx, goal_x), diff34(ny, goal_y)) < 66'(tol_sq);
    r.status = ST_ADDED;
    node_cnt++;
    return r;
  endfunction

  always @(posedge clk) begin
    extend_res_t e;
    if (rst) begin
      root_x = '0;
      root_y = '0;
      goal_x = '0;
      goal_y = '0;
      step_len = 24'd32768;
      goal_tol = 24'd66;
      clear_tree();
      extend_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: begin
            root_x = cfg_data;
            clear_tree();
          end
          REG_START_Y: begin
            root_y = cfg_data;
            clear_tree();
          end
          REG_GOAL_X: goal_x = cfg_data;
          REG_GOAL_Y: goal_y = cfg_data;
          REG_STEP: step_len = cfg_data[23:0];
          REG_TOL: goal_tol = cfg_data[23:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (extend_q.size() == 0) begin
          $error("result transfer with no expectation: tdata %h tuser %h", m_tdata, m_tuser);
          err_cnt++;
        end else begin
          e = extend_q.pop_front();
          if (m_tdata[31:0] !== e.new_x) begin
            $error("new_x expected %h got %h", e.new_x, m_tdata[31:0]);
            err_cnt++;
          end
          if (m_tdata[63:32] !== e.new_y) begin
            $error("new_y expected %h got %h", e.new_y, m_tdata[63:32]);
            err_cnt++;
          end
          if (m_tdata[73:64] !== e.new_index) begin
            $error("new_index expected %0d got %0d", e.new_index, m_tdata[73:64]);
            err_cnt++;
          end
          if (m_tdata[83:74] !== e.parent_index) begin
            $error("parent_index expected %0d got %0d", e.parent_index, m_tdata[83:74]);
            err_cnt++;
          end
          if (m_tdata[84] !== e.goal_reached) begin
            $error("goal_reached expected %b got %b", e.goal_reached, m_tdata[84]);
            err_cnt++;
          end
          if (m_tuser !== e.status) begin
            $error("status expected %0d got %0d", e.status, m_tuser);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        extend_q.insert(extend_q.size(), extend(s_tdata[31:0], s_tdata[63:32]));
      end
    end
    errors <= err_cnt;
    pending <= extend_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the tree extension block: clock, reset, stimulus and verdict.
module tb_top;
  import rrt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = REG_TOL + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = REG_TOL + 3'd2;
  localparam int STALL_LIMIT = 30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors;
  int pending;

  logic hold_go = 1'b0;
  logic no_idle = 1'b0;
  logic [31:0] cur_sx = '0;
  logic [31:0] cur_sy = '0;
  int idle_cycles = 0;

  rrt_tree_extend_step u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rrt_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL rrt_tree_extend_step");
        $finish;
      end
    end
  end

  // The long hold lets the sender keep offering while the block backs up.
  initial begin
    int r;
    logic held;
    held = 1'b0;
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 95) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_sample(logic [31:0] x, logic [31:0] y);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_START_X) cur_sx = val;
    if (idx == REG_START_Y) cur_sy = val;
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] base, int mode);
    int off;
    case (mode)
      0: return $urandom;
      1: begin
        off = $urandom_range(0, 8);
        return base + 32'(off - 4);
      end
      default: begin
        off = $urandom_range(0, 2097152);
        return base + 32'(off - 1048576);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(0, 3))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'h00FFFFFF;
      3: return $urandom_range(1, 3);
      4: return $urandom;
      default: return 32'd32768;
    endcase
  endfunction

  task automatic run_phase(int n, int mode);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_sample(cur_sx, cur_sy);
      else send_sample(pick_coord(cur_sx, mode), pick_coord(cur_sy, mode));
    end
    drain();
  endtask

  task automatic random_setup();
    logic [31:0] sx, sy;
    sx = ($urandom_range(0, 1) == 0) ? pick_corner() : $urandom;
    sy = ($urandom_range(0, 1) == 0) ? pick_corner() : $urandom;
    set_reg(REG_START_X, sx);
    set_reg(REG_START_Y, sy);
    if ($urandom_range(0, 1) == 0) begin
      set_reg(REG_GOAL_X, sx + 32'($urandom_range(0, 64)));
      set_reg(REG_GOAL_Y, sy + 32'($urandom_range(0, 64)));
    end else begin
      set_reg(REG_GOAL_X, $urandom);
      set_reg(REG_GOAL_Y, $urandom);
    end
    set_reg(REG_STEP, pick_len());
    set_reg(REG_TOL, pick_len());
    set_reg(($urandom_range(0, 1) == 0) ? REG_NONE_LO : REG_NONE_HI, $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: a sample on the root, a plain step, the four corners, a short overshoot.
    send_sample(32'h0, 32'h0);
    send_sample(32'd65536, 32'h0);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_sample(32'h80000000, 32'h80000000);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    send_sample(32'h0, 32'h1);
    drain();

    // Saturation at both ends with the new node landing on the goal.
    set_reg(REG_START_X, 32'h7FFFFFF0);
    set_reg(REG_START_Y, 32'h80000010);
    set_reg(REG_STEP, 32'h00FFFFFF);
    set_reg(REG_GOAL_X, 32'h7FFFFFFF);
    set_reg(REG_GOAL_Y, 32'h80000000);
    set_reg(REG_TOL, 32'h1);
    set_reg(REG_NONE_HI, 32'hFFFFFFFF);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h7FFFFFF0, 32'h80000010);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    drain();

    // Zero step: duplicate nodes, ties resolved to the lowest index.
    set_reg(REG_START_X, 32'h0);
    set_reg(REG_START_Y, 32'h0);
    set_reg(REG_STEP, 32'h0);
    set_reg(REG_TOL, 32'h0);
    set_reg(REG_GOAL_X, 32'h0);
    set_reg(REG_GOAL_Y, 32'h0);
    send_sample(32'd5, 32'd5);
    send_sample(32'd5, 32'd5);
    send_sample(32'h0, 32'h0);
    send_sample(32'hFFFFFFFB, 32'd5);
    drain();

    hold_go <= 1'b1;
    for (int p = 0; p < 9; p++) begin
      no_idle = (p % 3 == 2);
      random_setup();
      run_phase(60, $urandom_range(0, 2));
    end

    no_idle = 1'b0;
    random_setup();
    run_phase(20, 1);

    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS rrt_tree_extend_step");
    else $display("FAIL rrt_tree_extend_step");
    $finish;
  end

endmodule
